[src/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[src/mkd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mkd_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int VAR_COUNT  = 8;

  localparam int KEY_W   = 64;
  localparam int VAR_W   = 3;
  localparam int STAT_W  = 3;
  localparam int HPOS_W  = 4;
  localparam int ECNT_W  = 5;
  localparam int CAP_W   = 5;
  localparam int ALLOW_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam int POS_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  localparam logic [CAP_W-1:0]   CAP_RESET   = CAP_W'(16);
  localparam logic [ALLOW_W-1:0] ALLOW_RESET = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY     = 1'b0,
    CFG_ALLOWED_VARS = 1'b1
  } cfg_idx_t;

  typedef enum logic [STAT_W-1:0] {
    ST_REJECTED = 3'd0,
    ST_HIT      = 3'd1,
    ST_GET_MISS = 3'd2,
    ST_INSERTED = 3'd3,
    ST_EVICTED  = 3'd4
  } status_t;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef struct packed {
    logic             command;
    logic [KEY_W-1:0] client_key;
    logic [VAR_W-1:0] var_index;
  } mkd_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [HPOS_W-1:0] hit_position;
    logic [KEY_W-1:0]  evicted_key;
    logic [ECNT_W-1:0] entry_count;
  } mkd_rsp_t;

  typedef struct packed {
    logic load;
    logic update;
  } mkd_cmd_t;

endpackage

`default_nettype wire

[src/mkd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mkd_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  output logic             busy,
  output logic             done,
  output mkd_pkg::mkd_cmd_t cmd
);
  import mkd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_UPDATE = 2'b10
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state == S_UPDATE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.update;
    end
  end

  `ASSERT_NEXT(a_load_busy, clk, rst, start && !busy, busy)
  `ASSERT_NEXT(a_busy_once, clk, rst, busy, !busy)
  `ASSERT_NEXT(a_busy_done, clk, rst, busy, done)
  `ASSERT_SAME(a_done_idle, clk, rst, done, !busy)

endmodule

`default_nettype wire

[src/mkd_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mkd_datapath (
  input  wire                               clk,
  input  wire                               rst,
  input  mkd_pkg::mkd_cmd_t                 cmd,
  input  mkd_pkg::mkd_req_t                 req,
  output mkd_pkg::mkd_rsp_t                 rsp,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [mkd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [mkd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mkd_pkg::*;

  logic [KEY_W-1:0]   key_list [LIST_DEPTH];
  logic [CNT_W-1:0]   key_count, key_count_next;
  logic [CAP_W-1:0]   capacity;
  logic [ALLOW_W-1:0] allowed_vars;

  logic               req_cmd;
  logic [KEY_W-1:0]   req_key;
  logic               req_ok;
  logic               req_hit;
  logic [POS_W-1:0]   req_pos;

  logic [LIST_DEPTH-1:0] match;
  logic                  match_any;
  logic [POS_W-1:0]      match_pos;
  logic                  var_ok;

  logic [CNT_W-1:0]  cap_eff;
  logic [CNT_W-1:0]  shift_n;
  logic              do_push;
  logic              full;
  logic [STAT_W-1:0] status_next;
  logic [KEY_W-1:0]  evict_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity     <= CAP_RESET;
      allowed_vars <= ALLOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CAPACITY:     capacity     <= cfg_data[CAP_W-1:0];
        CFG_ALLOWED_VARS: allowed_vars <= cfg_data[ALLOW_W-1:0];
        default: ;
      endcase
    end
  end

  // parallel compare, first match wins
  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      match[i] = (CNT_W'(i) < key_count) && (key_list[i] == req.client_key);
    end
    match_any = |match;
    match_pos = '0;
    for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
      if (match[i]) match_pos = POS_W'(i);
    end
  end

  assign var_ok = (32'(req.var_index) < VAR_COUNT) && allowed_vars[req.var_index];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_cmd <= req.command;
      req_key <= req.client_key;
      req_ok  <= var_ok;
      req_hit <= match_any;
      req_pos <= match_pos;
    end
  end

  always_comb begin
    if (32'(capacity) < 1) begin
      cap_eff = CNT_W'(1);
    end else if (32'(capacity) > LIST_DEPTH) begin
      cap_eff = CNT_W'(LIST_DEPTH);
    end else begin
      cap_eff = CNT_W'(capacity);
    end
    full           = (key_count >= cap_eff);
    evict_next     = '0;
    shift_n        = '0;
    do_push        = 1'b0;
    key_count_next = key_count;
    status_next    = ST_REJECTED;
    priority if (!req_ok) begin
      status_next = ST_REJECTED;
    end else if (req_hit) begin
      status_next = ST_HIT;
      do_push     = 1'b1;
      shift_n     = CNT_W'(req_pos);
    end else if (req_cmd == CMD_GET) begin
      status_next = ST_GET_MISS;
    end else if (full) begin
      status_next    = ST_EVICTED;
      do_push        = 1'b1;
      evict_next     = key_list[POS_W'(cap_eff - CNT_W'(1))];
      shift_n        = cap_eff - CNT_W'(1);
      key_count_next = cap_eff;
    end else begin
      status_next    = ST_INSERTED;
      do_push        = 1'b1;
      shift_n        = key_count;
      key_count_next = key_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && do_push) begin
      for (int i = 1; i < LIST_DEPTH; i++) begin
        if (CNT_W'(i) <= shift_n) key_list[i] <= key_list[i-1];
      end
      key_list[0] <= req_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= '0;
    end else if (cmd.update) begin
      key_count <= key_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      rsp.status       <= status_next;
      rsp.hit_position <= (status_next == ST_HIT) ? HPOS_W'(req_pos) : '0;
      rsp.evicted_key  <= evict_next;
      rsp.entry_count  <= ECNT_W'(key_count_next);
    end
  end

  `ASSERT_SAME(a_count_max, clk, rst, 1'b1, 32'(key_count) <= LIST_DEPTH)
  `ASSERT_NEXT(a_reject_keeps, clk, rst, cmd.update && !req_ok,
               key_count == $past(key_count))
  `ASSERT_NEXT(a_hit_keeps, clk, rst, cmd.update && req_ok && req_hit,
               key_count == $past(key_count))
  `ASSERT_SAME(a_evict_full, clk, rst, cmd.update && status_next == ST_EVICTED,
               key_count_next == cap_eff)

endmodule

`default_nettype wire

[src/mru_client_key_directory_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// MRU client key directory. A request is taken when start is high and busy is
// low; its key is compared against every held entry in that same cycle, and
// the list is reordered in the next cycle (busy high for that one cycle). The
// result shows on rsp with done high for exactly one cycle, the cycle after
// busy; it cannot be held off, so the receiver must take it then. A new
// request may start in that same cycle. Each request has a compare cycle and
// a list update; no start is taken while busy. Configuration (cfg_ready is
// always high) should be written only while no request is in flight.
module mru_client_key_directory_core (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           start,
  output logic                          busy,
  input  mkd_pkg::mkd_req_t             req,
  output logic                          done,
  output mkd_pkg::mkd_rsp_t             rsp,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [mkd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [mkd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mkd_pkg::*;

  mkd_cmd_t cmd;

  mkd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  mkd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire
